@@ rtl/sls_pkg.sv @@
// ----------------------------------------------------------------------------
// sls_pkg
// Types, codes and character classes shared by the string literal scanner.
// ----------------------------------------------------------------------------
package sls_pkg;

  // input item of the scanner
  typedef struct packed {
    logic        command;
    logic [4:0]  valid_mask;
    logic [20:0] char_code;
    logic        at_eof;
  } in_t;

  // result item of the scanner
  typedef struct packed {
    logic       advance;
    logic       end_mark;
    logic       done_res;
    logic       accepted;
    logic [2:0] token_kind;
  } out_t;

  // command codes
  localparam logic CMD_NEXT  = 1'b0;
  localparam logic CMD_BEGIN = 1'b1;

  // scan phase codes
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_RAW_OPEN  = 4'd1;
  localparam logic [3:0] PH_RAW_BODY  = 4'd2;
  localparam logic [3:0] PH_RAW_CLOSE = 4'd3;
  localparam logic [3:0] PH_RAW_TAIL  = 4'd4;
  localparam logic [3:0] PH_PLAIN     = 4'd5;
  localparam logic [3:0] PH_ESC_SEL   = 4'd6;
  localparam logic [3:0] PH_ESC_HEX   = 4'd7;

  // token kinds
  localparam logic [2:0] KIND_RAW_START   = 3'd0;
  localparam logic [2:0] KIND_RAW_CONTENT = 3'd1;
  localparam logic [2:0] KIND_RAW_END     = 3'd2;
  localparam logic [2:0] KIND_QUOTED      = 3'd3;
  localparam logic [2:0] KIND_ESCAPE      = 3'd4;

  // valid_mask bit positions
  localparam int unsigned MASK_RAW_START   = 0;
  localparam int unsigned MASK_RAW_CONTENT = 1;
  localparam int unsigned MASK_RAW_END     = 2;
  localparam int unsigned MASK_QUOTED      = 3;
  localparam int unsigned MASK_ESCAPE      = 4;

  // characters
  localparam logic [20:0] CH_QUOTE = 21'h22;
  localparam logic [20:0] CH_HASH  = 21'h23;
  localparam logic [20:0] CH_BSL   = 21'h5C;
  localparam logic [20:0] CH_SLASH = 21'h2F;
  localparam logic [20:0] CH_ZERO  = 21'h30;
  localparam logic [20:0] CH_NINE  = 21'h39;
  localparam logic [20:0] CH_UA    = 21'h41;
  localparam logic [20:0] CH_UF    = 21'h46;
  localparam logic [20:0] CH_LA    = 21'h61;
  localparam logic [20:0] CH_LF    = 21'h66;
  localparam logic [20:0] CH_LB    = 21'h62;
  localparam logic [20:0] CH_LN    = 21'h6E;
  localparam logic [20:0] CH_LR    = 21'h72;
  localparam logic [20:0] CH_LT    = 21'h74;
  localparam logic [20:0] CH_LX    = 21'h78;
  localparam logic [20:0] CH_LU    = 21'h75;
  localparam logic [20:0] CH_UU    = 21'h55;
  localparam logic [20:0] CH_TAB   = 21'h09;
  localparam logic [20:0] CH_VT    = 21'h0B;
  localparam logic [20:0] CH_US    = 21'h1F;
  localparam logic [20:0] CH_DEL   = 21'h7F;

  // hex digit counts per escape form
  localparam logic [3:0] HEX_LEN_X  = 4'd2;
  localparam logic [3:0] HEX_LEN_LU = 4'd4;
  localparam logic [3:0] HEX_LEN_UU = 4'd8;

  // control characters, the newline excepted
  function automatic logic is_ctrl(input logic [20:0] c);
    return (c <= CH_TAB) || ((c >= CH_VT) && (c <= CH_US)) || (c == CH_DEL);
  endfunction

  function automatic logic is_hex(input logic [20:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_UA) && (c <= CH_UF)) ||
           ((c >= CH_LA) && (c <= CH_LF));
  endfunction

  function automatic logic is_single_escape(input logic [20:0] c);
    return (c == CH_QUOTE) || (c == CH_BSL) || (c == CH_SLASH) || (c == CH_LB) ||
           (c == CH_LF) || (c == CH_LN) || (c == CH_LR) || (c == CH_LT) ||
           (c == CH_ZERO);
  endfunction

endpackage

@@ rtl/sls_step.sv @@
// ----------------------------------------------------------------------------
// sls_step
// Scan state registers and the combinational transition that turns one
// lookahead character into one result.
// ----------------------------------------------------------------------------
module sls_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_en_i,
  input  sls_pkg::in_t  item_i,
  output sls_pkg::out_t res_o
);

  logic [3:0] phase_q, phase_d;
  logic [7:0] open_hash_q, open_hash_d;
  logic [7:0] hash_prog_q, hash_prog_d;
  logic [3:0] hex_left_q, hex_left_d;

  logic [20:0] c;
  logic        eof;
  logic        is_quote, is_hash, is_bsl, ctrl;

  // raw content character outcome, shared by several paths
  sls_pkg::out_t body_res;
  logic [3:0]    body_phase;
  logic          body_clr_prog;

  // raw opening outcome with a given hash count
  logic [7:0]    open_prog;
  logic [7:0]    prog_inc;
  logic [7:0]    open_inc;
  logic [3:0]    hex_dec;

  assign c        = item_i.char_code;
  assign eof      = item_i.at_eof;
  assign is_quote = (c == sls_pkg::CH_QUOTE);
  assign is_hash  = (c == sls_pkg::CH_HASH);
  assign is_bsl   = (c == sls_pkg::CH_BSL);
  assign ctrl     = sls_pkg::is_ctrl(c);
  assign prog_inc = hash_prog_q + 8'd1;
  assign hex_dec  = hex_left_q - 4'd1;

  // opening hash count restarts on a begin
  assign open_prog = (item_i.command == sls_pkg::CMD_BEGIN) ? 8'd0 : hash_prog_q;
  assign open_inc  = open_prog + 8'd1;

  // raw content character
  always_comb begin
    body_res      = '0;
    body_phase    = sls_pkg::PH_IDLE;
    body_clr_prog = 1'b0;
    body_res.token_kind = sls_pkg::KIND_RAW_CONTENT;
    if (eof || (!is_quote && ctrl)) begin
      body_res.done_res = 1'b1;
    end else if (is_quote) begin
      body_res.advance  = 1'b1;
      body_res.end_mark = 1'b1;
      if (open_hash_q == 8'd0) begin
        body_res.done_res = 1'b1;
        body_res.accepted = 1'b1;
      end else begin
        body_clr_prog = 1'b1;
        body_phase    = sls_pkg::PH_RAW_CLOSE;
      end
    end else begin
      body_res.advance = 1'b1;
      body_phase       = sls_pkg::PH_RAW_BODY;
    end
  end

  // next state and result
  always_comb begin
    phase_d     = phase_q;
    open_hash_d = open_hash_q;
    hash_prog_d = hash_prog_q;
    hex_left_d  = hex_left_q;
    res_o       = '0;

    if (item_i.command == sls_pkg::CMD_BEGIN) begin
      priority if (item_i.valid_mask[sls_pkg::MASK_RAW_START]) begin
        res_o.token_kind = sls_pkg::KIND_RAW_START;
        hash_prog_d      = 8'd0;
        if (is_hash) begin
          hash_prog_d   = open_inc;
          phase_d       = sls_pkg::PH_RAW_OPEN;
          res_o.advance = 1'b1;
        end else if (is_quote) begin
          open_hash_d    = open_prog;
          phase_d        = sls_pkg::PH_IDLE;
          res_o.advance  = 1'b1;
          res_o.done_res = 1'b1;
          res_o.accepted = 1'b1;
        end else begin
          phase_d        = sls_pkg::PH_IDLE;
          res_o.done_res = 1'b1;
        end
      end else if (item_i.valid_mask[sls_pkg::MASK_RAW_CONTENT]) begin
        res_o   = body_res;
        phase_d = body_phase;
        if (body_clr_prog) begin
          hash_prog_d = 8'd0;
        end
      end else if (item_i.valid_mask[sls_pkg::MASK_RAW_END] && is_quote) begin
        res_o.token_kind = sls_pkg::KIND_RAW_END;
        res_o.advance    = 1'b1;
        if (open_hash_q == 8'd0) begin
          phase_d        = sls_pkg::PH_IDLE;
          res_o.done_res = 1'b1;
          res_o.accepted = 1'b1;
        end else begin
          hash_prog_d = 8'd0;
          phase_d     = sls_pkg::PH_RAW_TAIL;
        end
      end else if (item_i.valid_mask[sls_pkg::MASK_QUOTED] &&
                   item_i.valid_mask[sls_pkg::MASK_ESCAPE]) begin
        if (is_quote || ctrl) begin
          phase_d          = sls_pkg::PH_IDLE;
          res_o.done_res   = 1'b1;
          res_o.token_kind = sls_pkg::KIND_QUOTED;
        end else if (is_bsl) begin
          phase_d          = sls_pkg::PH_ESC_SEL;
          res_o.advance    = 1'b1;
          res_o.token_kind = sls_pkg::KIND_ESCAPE;
        end else begin
          phase_d          = sls_pkg::PH_PLAIN;
          res_o.advance    = 1'b1;
          res_o.token_kind = sls_pkg::KIND_QUOTED;
        end
      end else begin
        phase_d          = sls_pkg::PH_IDLE;
        res_o.done_res   = 1'b1;
        res_o.token_kind = sls_pkg::KIND_RAW_START;
      end
    end else begin
      unique case (phase_q)
        sls_pkg::PH_RAW_OPEN: begin
          res_o.token_kind = sls_pkg::KIND_RAW_START;
          if (is_hash) begin
            hash_prog_d   = open_inc;
            res_o.advance = 1'b1;
          end else if (is_quote) begin
            open_hash_d    = open_prog;
            phase_d        = sls_pkg::PH_IDLE;
            res_o.advance  = 1'b1;
            res_o.done_res = 1'b1;
            res_o.accepted = 1'b1;
          end else begin
            phase_d        = sls_pkg::PH_IDLE;
            res_o.done_res = 1'b1;
          end
        end
        sls_pkg::PH_RAW_BODY: begin
          res_o   = body_res;
          phase_d = body_phase;
          if (body_clr_prog) begin
            hash_prog_d = 8'd0;
          end
        end
        sls_pkg::PH_RAW_CLOSE: begin
          if (is_hash && (hash_prog_q < open_hash_q)) begin
            hash_prog_d      = prog_inc;
            res_o.advance    = 1'b1;
            res_o.token_kind = sls_pkg::KIND_RAW_CONTENT;
            if (prog_inc == open_hash_q) begin
              phase_d        = sls_pkg::PH_IDLE;
              res_o.done_res = 1'b1;
              res_o.accepted = 1'b1;
            end
          end else begin
            // a short hash run falls back to content
            res_o   = body_res;
            phase_d = body_phase;
            if (body_clr_prog) begin
              hash_prog_d = 8'd0;
            end
          end
        end
        sls_pkg::PH_RAW_TAIL: begin
          res_o.token_kind = sls_pkg::KIND_RAW_END;
          if (is_hash) begin
            hash_prog_d   = prog_inc;
            res_o.advance = 1'b1;
            if (prog_inc == open_hash_q) begin
              phase_d        = sls_pkg::PH_IDLE;
              res_o.done_res = 1'b1;
              res_o.accepted = 1'b1;
            end
          end else begin
            phase_d        = sls_pkg::PH_IDLE;
            res_o.done_res = 1'b1;
          end
        end
        sls_pkg::PH_PLAIN: begin
          res_o.token_kind = sls_pkg::KIND_QUOTED;
          if (is_quote || is_bsl || ctrl) begin
            phase_d        = sls_pkg::PH_IDLE;
            res_o.done_res = 1'b1;
            res_o.accepted = 1'b1;
          end else begin
            res_o.advance = 1'b1;
          end
        end
        sls_pkg::PH_ESC_SEL: begin
          res_o.token_kind = sls_pkg::KIND_ESCAPE;
          if ((c == sls_pkg::CH_LX) || (c == sls_pkg::CH_LU) || (c == sls_pkg::CH_UU)) begin
            hex_left_d    = (c == sls_pkg::CH_LX) ? sls_pkg::HEX_LEN_X :
                            ((c == sls_pkg::CH_LU) ? sls_pkg::HEX_LEN_LU : sls_pkg::HEX_LEN_UU);
            phase_d       = sls_pkg::PH_ESC_HEX;
            res_o.advance = 1'b1;
          end else if (sls_pkg::is_single_escape(c)) begin
            phase_d        = sls_pkg::PH_IDLE;
            res_o.advance  = 1'b1;
            res_o.done_res = 1'b1;
            res_o.accepted = 1'b1;
          end else begin
            phase_d        = sls_pkg::PH_IDLE;
            res_o.done_res = 1'b1;
          end
        end
        sls_pkg::PH_ESC_HEX: begin
          res_o.token_kind = sls_pkg::KIND_ESCAPE;
          if (!sls_pkg::is_hex(c)) begin
            phase_d        = sls_pkg::PH_IDLE;
            res_o.done_res = 1'b1;
          end else begin
            hex_left_d    = hex_dec;
            res_o.advance = 1'b1;
            if (hex_dec == 4'd0) begin
              phase_d        = sls_pkg::PH_IDLE;
              res_o.done_res = 1'b1;
              res_o.accepted = 1'b1;
            end
          end
        end
        default: begin
          // idle or unused code: report a failed scan
          phase_d          = sls_pkg::PH_IDLE;
          res_o.done_res   = 1'b1;
          res_o.token_kind = sls_pkg::KIND_RAW_START;
        end
      endcase
    end
  end

  // scan state, updated once per transfer into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sls_pkg::PH_IDLE;
      open_hash_q <= 8'd0;
      hash_prog_q <= 8'd0;
      hex_left_q  <= 4'd0;
    end else if (step_en_i) begin
      phase_q     <= phase_d;
      open_hash_q <= open_hash_d;
      hash_prog_q <= hash_prog_d;
      hex_left_q  <= hex_left_d;
    end
  end

endmodule

@@ rtl/string_literal_token_scanner.sv @@
// ----------------------------------------------------------------------------
// string_literal_token_scanner
// Character-at-a-time scanner for raw and quoted string literal tokens.
// ----------------------------------------------------------------------------
// The scanner takes one lookahead character per cycle while it is not stalled
// and returns exactly one result for each one, in order. An accepted character
// is held in an input register; once the output register is free the scan
// transition works on it and the result lands in the output register. Throughput
// is one character per cycle while the output is not stalled, as the scan state
// registers update once per step. The input side keeps taking characters while
// a result waits, and stalls only when both the input and the output registers
// are full and the output is stalled.
module string_literal_token_scanner (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sls_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sls_pkg::out_t out_data_o
);

  logic          in_valid_q;
  sls_pkg::in_t  in_q;
  logic          out_valid_q;
  sls_pkg::out_t out_q;
  sls_pkg::out_t res;
  logic          out_free;
  logic          step_en;
  logic          in_take;

  // pipeline flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_en    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // scan transition and state
  sls_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (in_q),
    .res_o     (res)
  );

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step_en) begin
      in_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step_en;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/string_literal_token_scanner_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_literal_token_scanner_tb
// Self-checking bench for the string literal scanner. A directed table walks
// every token kind and several failure paths. Random scans follow, shaped by the scan
// state so most of them reach the accepting paths, under four idle patterns.
// Every result is checked against a cycle-free scanner model in the bench.
// ----------------------------------------------------------------------------
module string_literal_token_scanner_tb;
  import sls_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int N_DIR        = 26;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [4:0] ALLOW_NONE    = 5'b00000;
  localparam logic [4:0] ALLOW_ALL     = 5'b11111;
  localparam logic [4:0] ALLOW_START   = 5'b1 << MASK_RAW_START;
  localparam logic [4:0] ALLOW_CONTENT = 5'b1 << MASK_RAW_CONTENT;
  localparam logic [4:0] ALLOW_END     = 5'b1 << MASK_RAW_END;
  localparam logic [4:0] ALLOW_QUOTED  = 5'b1 << MASK_QUOTED;
  localparam logic [4:0] ALLOW_ESCAPE  = 5'b1 << MASK_ESCAPE;
  localparam logic [4:0] ALLOW_STRING  = ALLOW_QUOTED | ALLOW_ESCAPE;

  localparam logic [20:0] CH_MAX = 21'h10FFFF;
  localparam logic [20:0] CH_LQ  = 21'h71;

  localparam logic [20:0] ONE_CHAR_ESC [9] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_LB, CH_LF,
                                                CH_LN, CH_LR, CH_LT, CH_ZERO};
  localparam logic [20:0] HEX_ESC_SEL [3] = '{CH_LX, CH_LU, CH_UU};

  typedef struct {
    in_t  item;
    bit   fixed;
    out_t result;
  } stim_row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // scanner model state
  logic [3:0] sc_phase       = PH_IDLE;
  logic [7:0] sc_open_hashes = '0;
  logic [7:0] sc_hash_count  = '0;
  logic [3:0] sc_hex_left    = '0;

  out_t      expected_outcomes [$];
  stim_row_t dir_rows [N_DIR];
  int        items_sent     = 0;
  int        errors         = 0;
  int        cycle_count    = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  bit        quiet          = 1'b0;

  string_literal_token_scanner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // character classes
  function automatic bit is_control_code(input logic [20:0] c);
    return (c <= CH_TAB) || ((c >= CH_VT) && (c <= CH_US)) || (c == CH_DEL);
  endfunction

  function automatic bit is_hex_code(input logic [20:0] c);
    return (c inside {[CH_ZERO:CH_NINE], [CH_UA:CH_UF], [CH_LA:CH_LF]});
  endfunction

  function automatic bit is_plain_escape(input logic [20:0] c);
    bit hit;
    hit = 1'b0;
    foreach (ONE_CHAR_ESC[i]) if (c == ONE_CHAR_ESC[i]) hit = 1'b1;
    return hit;
  endfunction

  function automatic out_t make_outcome(input logic adv, input logic mark, input logic done,
                                        input logic acc, input logic [2:0] kind);
    out_t r;
    r.advance    = adv;
    r.end_mark   = mark;
    r.done_res   = done;
    r.accepted   = acc;
    r.token_kind = kind;
    return r;
  endfunction

  function automatic out_t finish_scan(input logic adv, input logic mark, input logic acc,
                                       input logic [2:0] kind);
    sc_phase = PH_IDLE;
    return make_outcome(adv, mark, 1'b1, acc, kind);
  endfunction

  // raw content body character, also the fallback of a broken close
  function automatic out_t body_step(input logic [20:0] c, input logic eof);
    if (eof) return finish_scan(1'b0, 1'b0, 1'b0, KIND_RAW_CONTENT);
    if (c == CH_QUOTE) begin
      if (sc_open_hashes == 0) return finish_scan(1'b1, 1'b1, 1'b1, KIND_RAW_CONTENT);
      sc_hash_count = '0;
      sc_phase      = PH_RAW_CLOSE;
      return make_outcome(1'b1, 1'b1, 1'b0, 1'b0, KIND_RAW_CONTENT);
    end
    if (is_control_code(c)) return finish_scan(1'b0, 1'b0, 1'b0, KIND_RAW_CONTENT);
    sc_phase = PH_RAW_BODY;
    return make_outcome(1'b1, 1'b0, 1'b0, 1'b0, KIND_RAW_CONTENT);
  endfunction

  // one lookahead character of a running scan
  function automatic out_t phase_step(input logic [20:0] c, input logic eof);
    case (sc_phase)
      PH_RAW_OPEN: begin
        if (c == CH_HASH) begin
          sc_hash_count = sc_hash_count + 8'd1;
          return make_outcome(1'b1, 1'b0, 1'b0, 1'b0, KIND_RAW_START);
        end
        if (c == CH_QUOTE) begin
          sc_open_hashes = sc_hash_count;
          return finish_scan(1'b1, 1'b0, 1'b1, KIND_RAW_START);
        end
        return finish_scan(1'b0, 1'b0, 1'b0, KIND_RAW_START);
      end
      PH_RAW_BODY: return body_step(c, eof);
      PH_RAW_CLOSE: begin
        if ((c == CH_HASH) && (sc_hash_count < sc_open_hashes)) begin
          sc_hash_count = sc_hash_count + 8'd1;
          if (sc_hash_count == sc_open_hashes)
            return finish_scan(1'b1, 1'b0, 1'b1, KIND_RAW_CONTENT);
          return make_outcome(1'b1, 1'b0, 1'b0, 1'b0, KIND_RAW_CONTENT);
        end
        return body_step(c, eof);
      end
      PH_RAW_TAIL: begin
        if (c != CH_HASH) return finish_scan(1'b0, 1'b0, 1'b0, KIND_RAW_END);
        sc_hash_count = sc_hash_count + 8'd1;
        if (sc_hash_count == sc_open_hashes) return finish_scan(1'b1, 1'b0, 1'b1, KIND_RAW_END);
        return make_outcome(1'b1, 1'b0, 1'b0, 1'b0, KIND_RAW_END);
      end
      PH_PLAIN: begin
        if ((c == CH_QUOTE) || (c == CH_BSL) || is_control_code(c))
          return finish_scan(1'b0, 1'b0, 1'b1, KIND_QUOTED);
        return make_outcome(1'b1, 1'b0, 1'b0, 1'b0, KIND_QUOTED);
      end
      PH_ESC_SEL: begin
        if ((c == CH_LX) || (c == CH_LU) || (c == CH_UU)) begin
          sc_hex_left = (c == CH_LX) ? HEX_LEN_X : (c == CH_LU) ? HEX_LEN_LU : HEX_LEN_UU;
          sc_phase    = PH_ESC_HEX;
          return make_outcome(1'b1, 1'b0, 1'b0, 1'b0, KIND_ESCAPE);
        end
        if (is_plain_escape(c)) return finish_scan(1'b1, 1'b0, 1'b1, KIND_ESCAPE);
        return finish_scan(1'b0, 1'b0, 1'b0, KIND_ESCAPE);
      end
      PH_ESC_HEX: begin
        if (!is_hex_code(c)) return finish_scan(1'b0, 1'b0, 1'b0, KIND_ESCAPE);
        sc_hex_left = sc_hex_left - 4'd1;
        if (sc_hex_left == 0) return finish_scan(1'b1, 1'b0, 1'b1, KIND_ESCAPE);
        return make_outcome(1'b1, 1'b0, 1'b0, 1'b0, KIND_ESCAPE);
      end
      default: return finish_scan(1'b0, 1'b0, 1'b0, KIND_RAW_START);
    endcase
  endfunction

  // expected result of one transferred character, updates the model state
  function automatic out_t scan_step(input in_t it);
    logic [20:0] c;
    c = it.char_code;
    if (it.command == CMD_NEXT) return phase_step(c, it.at_eof);
    if (it.valid_mask[MASK_RAW_START]) begin
      sc_hash_count = '0;
      sc_phase      = PH_RAW_OPEN;
      return phase_step(c, it.at_eof);
    end
    if (it.valid_mask[MASK_RAW_CONTENT]) begin
      sc_phase = PH_RAW_BODY;
      return body_step(c, it.at_eof);
    end
    if (it.valid_mask[MASK_RAW_END] && (c == CH_QUOTE)) begin
      if (sc_open_hashes == 0) return finish_scan(1'b1, 1'b0, 1'b1, KIND_RAW_END);
      sc_hash_count = '0;
      sc_phase      = PH_RAW_TAIL;
      return make_outcome(1'b1, 1'b0, 1'b0, 1'b0, KIND_RAW_END);
    end
    if (it.valid_mask[MASK_QUOTED] && it.valid_mask[MASK_ESCAPE]) begin
      if ((c == CH_QUOTE) || is_control_code(c))
        return finish_scan(1'b0, 1'b0, 1'b0, KIND_QUOTED);
      if (c == CH_BSL) begin
        sc_phase = PH_ESC_SEL;
        return make_outcome(1'b1, 1'b0, 1'b0, 1'b0, KIND_ESCAPE);
      end
      sc_phase = PH_PLAIN;
      return make_outcome(1'b1, 1'b0, 1'b0, 1'b0, KIND_QUOTED);
    end
    return finish_scan(1'b0, 1'b0, 1'b0, KIND_RAW_START);
  endfunction

  function automatic stim_row_t row(input logic cmd, input logic [4:0] mask,
                                    input logic [20:0] ch, input logic eof,
                                    input bit fixed, input out_t result);
    stim_row_t r;
    r.item.command    = cmd;
    r.item.valid_mask = mask;
    r.item.char_code  = ch;
    r.item.at_eof     = eof;
    r.fixed           = fixed;
    r.result          = result;
    return r;
  endfunction

  // character pickers
  function automatic logic [20:0] content_code();
    int r;
    r = $urandom_range(9);
    if (r < 7) return 21'($urandom_range(32, 126));
    if (r < 9) return 21'($urandom_range(128, 16'hFFFF));
    return 21'($urandom_range(17'h10000, CH_MAX));
  endfunction

  function automatic logic [20:0] control_code();
    int r;
    r = $urandom_range(31);
    return (r == 10) ? CH_DEL : 21'(r);
  endfunction

  function automatic logic [20:0] any_code();
    if ($urandom_range(1)) return 21'($urandom_range(0, CH_MAX));
    return 21'($urandom_range(0, 127));
  endfunction

  function automatic logic [20:0] hex_code();
    int r;
    r = $urandom_range(21);
    if (r < 10) return 21'(CH_ZERO + r);
    if (r < 16) return 21'(CH_UA + r - 10);
    return 21'(CH_LA + r - 16);
  endfunction

  // one character transfer, with random idle cycles ahead of it
  task automatic send_item(input in_t it, input bit fixed, input out_t typed);
    int   gaps;
    out_t predicted;
    gaps = 0;
    if (!quiet) while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid_i <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = scan_step(it);
    expected_outcomes.push_back(fixed ? typed : predicted);
    items_sent++;
  endtask

  task automatic send_char(input logic cmd, input logic [4:0] mask, input logic [20:0] ch,
                           input logic eof);
    in_t it;
    it.command    = cmd;
    it.valid_mask = mask;
    it.char_code  = ch;
    it.at_eof     = eof;
    send_item(it, 1'b0, '0);
  endtask

  // sender holds off until every pending result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_outcomes.size() != 0);
  endtask

  // now and then a fresh begin cuts a running scan short
  task automatic maybe_abandon(output bit gone);
    gone = ($urandom_range(49) == 0);
    if (gone) send_char(CMD_BEGIN, 5'($urandom), any_code(), 1'($urandom));
  endtask

  task automatic scan_raw_start();
    int          n;
    int          brk;
    logic [20:0] ch;
    // rarely enough hashes to wrap the count
    n   = ($urandom_range(39) == 0) ? $urandom_range(255, 260) : $urandom_range(0, 4);
    brk = ($urandom_range(9) == 0) ? $urandom_range(0, n) : -1;
    for (int k = 0; k <= n; k++) begin
      ch = (k == n) ? CH_QUOTE : CH_HASH;
      if (k == brk) ch = any_code();
      send_char((k == 0) ? CMD_BEGIN : CMD_NEXT, ALLOW_START | 5'($urandom), ch,
                1'($urandom));
      if (sc_phase == PH_IDLE) break;
    end
  endtask

  task automatic scan_raw_content();
    int          r;
    int          len;
    bit          honest;
    bit          gone;
    logic [20:0] ch;
    r      = $urandom_range(9);
    ch     = (r == 0) ? CH_QUOTE : (r == 1) ? any_code() : content_code();
    honest = ($urandom_range(3) != 0);
    len    = 0;
    send_char(CMD_BEGIN, ALLOW_CONTENT | (5'($urandom) & ~ALLOW_START), ch,
              $urandom_range(49) == 0);
    while (sc_phase != PH_IDLE) begin
      maybe_abandon(gone);
      if (gone) break;
      len++;
      if (sc_phase == PH_RAW_CLOSE) begin
        // an honest close sends all hashes, a false one breaks off early
        ch = (honest || $urandom_range(1)) ? CH_HASH : content_code();
      end else begin
        r = $urandom_range(99);
        if ((len > 24) || (r < 25)) begin
          ch     = CH_QUOTE;
          honest = ($urandom_range(3) != 0) || (len > 24);
        end else if (r < 92) begin
          ch = content_code();
        end else if (r < 96) begin
          ch = control_code();
        end else begin
          ch = any_code();
        end
      end
      send_char(CMD_NEXT, 5'($urandom), ch, $urandom_range(49) == 0);
    end
  endtask

  task automatic scan_raw_end();
    bit          gone;
    logic [20:0] ch;
    ch = ($urandom_range(9) == 0) ? any_code() : CH_QUOTE;
    send_char(CMD_BEGIN, ALLOW_END | (5'($urandom) & ALLOW_STRING), ch, 1'($urandom));
    while (sc_phase != PH_IDLE) begin
      maybe_abandon(gone);
      if (gone) break;
      ch = ($urandom_range(24) == 0) ? any_code() : CH_HASH;
      send_char(CMD_NEXT, 5'($urandom), ch, 1'($urandom));
    end
  endtask

  task automatic scan_plain();
    int          len;
    bit          gone;
    logic [20:0] ch;
    len = 0;
    send_char(CMD_BEGIN, ALLOW_STRING | (5'($urandom) & ALLOW_END), content_code(),
              1'($urandom));
    while (sc_phase != PH_IDLE) begin
      maybe_abandon(gone);
      if (gone) break;
      len++;
      if ((len > 20) || ($urandom_range(99) < 15)) begin
        case ($urandom_range(2))
          0:       ch = CH_QUOTE;
          1:       ch = CH_BSL;
          default: ch = control_code();
        endcase
      end else begin
        ch = content_code();
      end
      send_char(CMD_NEXT, 5'($urandom), ch, 1'($urandom));
    end
  endtask

  task automatic scan_escape();
    int          r;
    bit          gone;
    logic [20:0] ch;
    send_char(CMD_BEGIN, ALLOW_STRING | (5'($urandom) & ALLOW_END), CH_BSL, 1'($urandom));
    if (sc_phase == PH_ESC_SEL) begin
      r = $urandom_range(99);
      if (r < 35) ch = ONE_CHAR_ESC[$urandom_range(8)];
      else if (r < 85) ch = HEX_ESC_SEL[$urandom_range(2)];
      else ch = any_code();
      send_char(CMD_NEXT, 5'($urandom), ch, 1'($urandom));
    end
    while (sc_phase == PH_ESC_HEX) begin
      maybe_abandon(gone);
      if (gone) break;
      ch = ($urandom_range(14) == 0) ? any_code() : hex_code();
      send_char(CMD_NEXT, 5'($urandom), ch, 1'($urandom));
    end
  endtask

  // unshaped characters, also steps with no scan running
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) send_char(1'($urandom), 5'($urandom), any_code(), 1'($urandom));
  endtask

  task automatic random_scan();
    int pick;
    pick  = $urandom_range(99);
    quiet = ($urandom_range(7) == 0);
    if (pick < 20) scan_raw_start();
    else if (pick < 42) scan_raw_content();
    else if (pick < 54) scan_raw_end();
    else if (pick < 68) scan_plain();
    else if (pick < 88) scan_escape();
    else send_noise();
  endtask

  // compare one result transfer with the oldest expectation
  task automatic check_outcome(input out_t got);
    out_t want;
    if (expected_outcomes.size() == 0) begin
      $error("result with nothing pending: %h", got);
      errors++;
      return;
    end
    want = expected_outcomes.pop_front();
    if (got.advance !== want.advance) begin
      $error("advance: expected %0d, got %0d", want.advance, got.advance);
      errors++;
    end
    if (got.end_mark !== want.end_mark) begin
      $error("end_mark: expected %0d, got %0d", want.end_mark, got.end_mark);
      errors++;
    end
    if (got.done_res !== want.done_res) begin
      $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
      errors++;
    end
    if (got.accepted !== want.accepted) begin
      $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
      errors++;
    end
    if (got.token_kind !== want.token_kind) begin
      $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
      errors++;
    end
  endtask

  // result side: check transfers, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_outcome(out_data_o);
      out_stall_i <= !quiet && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // main sequence
  initial begin
    int target;
    dir_rows = '{
      // step with no scan running
      row(CMD_NEXT,  ALLOW_NONE,    CH_LA,    1'b0, 1'b1,
          make_outcome(1'b0, 1'b0, 1'b1, 1'b0, KIND_RAW_START)),
      // nothing allowed, largest code point
      row(CMD_BEGIN, ALLOW_NONE,    CH_MAX,   1'b1, 1'b1,
          make_outcome(1'b0, 1'b0, 1'b1, 1'b0, KIND_RAW_START)),
      // raw start with two hashes
      row(CMD_BEGIN, ALLOW_ALL,     CH_HASH,  1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_HASH,  1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_QUOTE, 1'b0, 1'b0, '0),
      // raw content with a false close, then a real one
      row(CMD_BEGIN, ALLOW_CONTENT, CH_LA,    1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_QUOTE, 1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_HASH,  1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_LB,    1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_QUOTE, 1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_HASH,  1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_HASH,  1'b0, 1'b0, '0),
      // raw end
      row(CMD_BEGIN, ALLOW_END,     CH_QUOTE, 1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_HASH,  1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_HASH,  1'b0, 1'b0, '0),
      // raw end without its quote
      row(CMD_BEGIN, ALLOW_END,     CH_LA,    1'b0, 1'b1,
          make_outcome(1'b0, 1'b0, 1'b1, 1'b0, KIND_RAW_START)),
      // quoted run stopped by a backslash
      row(CMD_BEGIN, ALLOW_STRING,  CH_MAX,   1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_BSL,   1'b0, 1'b0, '0),
      // two-digit hex escape
      row(CMD_BEGIN, ALLOW_STRING,  CH_BSL,   1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_LX,    1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_UF,    1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_LF,    1'b0, 1'b0, '0),
      // unknown escape character
      row(CMD_BEGIN, ALLOW_STRING,  CH_BSL,   1'b0, 1'b0, '0),
      row(CMD_NEXT,  ALLOW_NONE,    CH_LQ,    1'b0, 1'b1,
          make_outcome(1'b0, 1'b0, 1'b1, 1'b0, KIND_ESCAPE)),
      // code zero is a control character
      row(CMD_BEGIN, ALLOW_STRING,  '0,       1'b0, 1'b1,
          make_outcome(1'b0, 1'b0, 1'b1, 1'b0, KIND_QUOTED)),
      // end of input inside raw content
      row(CMD_BEGIN, ALLOW_CONTENT, CH_LX,    1'b1, 1'b1,
          make_outcome(1'b0, 1'b0, 1'b1, 1'b0, KIND_RAW_CONTENT))
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIR; i++)
      send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].result);
    drain_results();

    // random scans under each idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) random_scan();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
